[rtl/pfsa_pkg.sv]
// pfsa_pkg: shared types and codes of the page-frame stack allocator.
// Request kinds, result status codes, controller states, stack control structs.
// No dependencies.
package pfsa_pkg;

  localparam int PAGE_ADDR_W = 48;
  localparam int FRAME_W     = 36;
  localparam int STATUS_W    = 2;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 36;
  localparam int NUM_CFG_REGS = 8;

  typedef enum logic {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_STACK  = 2'd0,
    STAT_REGION = 2'd1,
    STAT_OOM    = 2'd2,
    STAT_FREE   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MUL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stack_ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } stack_stat_t;

endpackage

[rtl/pfsa_in_if.sv]
// pfsa_in_if: request channel (valid/ready) of the page-frame stack allocator.
// Depends on pfsa_pkg for field widths.
interface pfsa_in_if;
  logic                            valid;
  logic                            ready;
  logic                            func;
  logic [pfsa_pkg::PAGE_ADDR_W-1:0] freed_page;

  modport source (output valid, output func, output freed_page, input ready);
  modport sink   (input valid, input func, input freed_page, output ready);
endinterface

[rtl/pfsa_out_if.sv]
// pfsa_out_if: result channel (valid/ready) of the page-frame stack allocator.
// Depends on pfsa_pkg for field widths.
interface pfsa_out_if;
  logic                            valid;
  logic                            ready;
  logic [pfsa_pkg::PAGE_ADDR_W-1:0] page_address;
  logic [pfsa_pkg::STATUS_W-1:0]    status;
  logic                            ok;

  modport source (output valid, output page_address, output status, output ok, input ready);
  modport sink   (input valid, input page_address, input status, input ok, output ready);
endinterface

[rtl/pfsa_cfg_if.sv]
// pfsa_cfg_if: register write channel (valid/ready, index, data).
// Depends on pfsa_pkg for field widths.
interface pfsa_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [pfsa_pkg::CFG_IDX_W-1:0]  index;
  logic [pfsa_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/pfsa_stack.sv]
// pfsa_stack: LIFO of freed page addresses in a synchronous memory.
// Holds the fill count; pop data is registered.
// Depends on pfsa_pkg.
module pfsa_stack #(
  parameter int STACK_DEPTH = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pfsa_pkg::stack_ctl_t              ctl,
  input  logic [pfsa_pkg::PAGE_ADDR_W-1:0]  wdata,
  output pfsa_pkg::stack_stat_t             stat,
  output logic [pfsa_pkg::PAGE_ADDR_W-1:0]  rdata
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [pfsa_pkg::PAGE_ADDR_W-1:0] mem [STACK_DEPTH];
  logic [CW-1:0]                    count_r;
  logic [CW-1:0]                    count_nxt;
  logic [CW-1:0]                    top_cnt;
  logic [AW-1:0]                    push_idx;
  logic [AW-1:0]                    pop_idx;
  logic [pfsa_pkg::PAGE_ADDR_W-1:0] rdata_r;

  assign top_cnt    = count_r - CW'(1);
  assign push_idx   = count_r[AW-1:0];
  assign pop_idx    = top_cnt[AW-1:0];
  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == CW'(STACK_DEPTH));
  assign rdata      = rdata_r;

  always_comb begin
    count_nxt = count_r;
    if (ctl.push) begin
      count_nxt = count_r + CW'(1);
    end else if (ctl.pop) begin
      count_nxt = top_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[push_idx] <= wdata;
    end
    if (ctl.pop) begin
      rdata_r <= mem[pop_idx];
    end
  end

`ifndef SYNTHESIS
  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.push |-> !stat.full)
    else $error("push into full stack");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.pop |-> !stat.empty)
    else $error("pop from empty stack");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.push && !ctl.pop |=> count_r == $past(count_r) + CW'(1))
    else $error("count did not advance on push");
`endif

endmodule

[rtl/page_frame_stack_allocator.sv]
// page_frame_stack_allocator: top level; request controller, region cursors,
// config registers and result register. Depends on pfsa_pkg, the pfsa_*_if
// interfaces and pfsa_stack.
//
//  channel  | dir | handshake    | payload
//  in_if    | in  | valid/ready  | func, freed_page
//  out_if   | out | valid/ready  | page_address, status, ok
//  cfg_if   | in  | valid/ready  | index, data (ready always high)
//
// One request at a time: free goes ST_IDLE, ST_DONE; stack pop or out of
// memory ST_IDLE, ST_EXEC, ST_DONE; region allocate also ST_MUL (stack read,
// region compare, then the page-size multiply). A finished result parks in
// the output register so the next beat is taken while it waits. rst_n (sync)
// clears stack count, region cursors and config. Out stall holds the result
// in ST_DONE; in_if.ready is low until it moves.
module page_frame_stack_allocator #(
  parameter int STACK_DEPTH = 1024,
  parameter int PAGE_SIZE   = 4096,
  parameter int NUM_REGIONS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  pfsa_in_if.sink     in_if,
  pfsa_out_if.source  out_if,
  pfsa_cfg_if.sink    cfg_if
);

  localparam int RW    = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;
  localparam int PSW   = $clog2(PAGE_SIZE + 1);
  localparam int AW    = pfsa_pkg::PAGE_ADDR_W;
  localparam int FW    = pfsa_pkg::FRAME_W;
  localparam int PRODW = (FW + PSW > AW) ? FW + PSW : AW;
  localparam int CRW   = pfsa_pkg::CFG_IDX_W - 1;

  pfsa_pkg::state_t      state_r, state_nxt;
  pfsa_pkg::stack_ctl_t  stk_ctl;
  pfsa_pkg::stack_stat_t stk_stat;
  logic [AW-1:0]         stk_rdata;

  logic [FW-1:0] first_r [NUM_REGIONS];
  logic [FW-1:0] end_r   [NUM_REGIONS];
  logic [FW-1:0] used_r  [NUM_REGIONS];

  logic [FW:0]   sum      [NUM_REGIONS];
  logic [NUM_REGIONS-1:0] hit;
  logic          any_hit;
  logic [RW-1:0] sel;

  logic                  pop_r;
  logic [FW-1:0]         frame_r;
  logic [PRODW-1:0]      prod;
  logic [AW-1:0]         res_addr_r;
  pfsa_pkg::status_t     res_status_r;
  logic                  res_ok_r;

  logic [AW-1:0]         out_addr_r;
  pfsa_pkg::status_t     out_status_r;
  logic                  out_ok_r;
  logic                  out_valid_r;

  logic in_fire;
  logic out_free;
  logic is_free;
  logic cfg_fire;
  logic [CRW-1:0] cfg_reg;

  assign in_if.ready  = (state_r == pfsa_pkg::ST_IDLE);
  assign in_fire      = in_if.valid && in_if.ready;
  assign is_free      = (in_if.func == pfsa_pkg::FUNC_FREE);
  assign out_free     = !out_valid_r || out_if.ready;
  assign cfg_if.ready = 1'b1;
  assign cfg_fire     = cfg_if.valid;
  assign cfg_reg      = cfg_if.index[pfsa_pkg::CFG_IDX_W-1:1];

  assign stk_ctl.push = in_fire && is_free && !stk_stat.full;
  assign stk_ctl.pop  = in_fire && !is_free && !stk_stat.empty;

  pfsa_stack #(.STACK_DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (stk_ctl),
    .wdata (in_if.freed_page),
    .stat  (stk_stat),
    .rdata (stk_rdata)
  );

  always_comb begin
    any_hit = 1'b0;
    sel     = '0;
    for (int i = 0; i < NUM_REGIONS; i++) begin
      sum[i] = {1'b0, first_r[i]} + {1'b0, used_r[i]};
      hit[i] = (sum[i] < {1'b0, end_r[i]});
    end
    for (int i = NUM_REGIONS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        any_hit = 1'b1;
        sel     = RW'(i);
      end
    end
  end

  assign prod = {{(PRODW-FW){1'b0}}, frame_r} * PRODW'(PAGE_SIZE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pfsa_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = is_free ? pfsa_pkg::ST_DONE : pfsa_pkg::ST_EXEC;
        end
      end
      pfsa_pkg::ST_EXEC: begin
        if (pop_r || !any_hit) begin
          state_nxt = pfsa_pkg::ST_DONE;
        end else begin
          state_nxt = pfsa_pkg::ST_MUL;
        end
      end
      pfsa_pkg::ST_MUL: begin
        state_nxt = pfsa_pkg::ST_DONE;
      end
      pfsa_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = pfsa_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pfsa_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pfsa_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGIONS; i++) begin
        first_r[i] <= '0;
        end_r[i]   <= '0;
        used_r[i]  <= '0;
      end
    end else begin
      for (int i = 0; i < NUM_REGIONS; i++) begin
        if (cfg_fire && cfg_reg == CRW'(i)) begin
          if (cfg_if.index[0]) begin
            end_r[i] <= cfg_if.data;
          end else begin
            first_r[i] <= cfg_if.data;
          end
        end
        if (state_r == pfsa_pkg::ST_EXEC && !pop_r && any_hit && sel == RW'(i)) begin
          used_r[i] <= used_r[i] + FW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      pfsa_pkg::ST_IDLE: begin
        pop_r        <= !stk_stat.empty;
        res_addr_r   <= '0;
        res_status_r <= pfsa_pkg::STAT_FREE;
        res_ok_r     <= !stk_stat.full;
      end
      pfsa_pkg::ST_EXEC: begin
        frame_r <= sum[sel][FW-1:0];
        if (pop_r) begin
          res_addr_r   <= stk_rdata;
          res_status_r <= pfsa_pkg::STAT_STACK;
          res_ok_r     <= 1'b1;
        end else begin
          res_addr_r   <= '0;
          res_status_r <= pfsa_pkg::STAT_OOM;
          res_ok_r     <= 1'b0;
        end
      end
      pfsa_pkg::ST_MUL: begin
        res_addr_r   <= prod[AW-1:0];
        res_status_r <= pfsa_pkg::STAT_REGION;
        res_ok_r     <= 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == pfsa_pkg::ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == pfsa_pkg::ST_DONE && out_free) begin
      out_addr_r   <= res_addr_r;
      out_status_r <= res_status_r;
      out_ok_r     <= res_ok_r;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.page_address = out_addr_r;
  assign out_if.status       = out_status_r;
  assign out_if.ok           = out_ok_r;

`ifndef SYNTHESIS
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_if.ready)
    else $error("second request taken while one is in flight");

  a_fail_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r == pfsa_pkg::STAT_OOM || out_status_r == pfsa_pkg::STAT_FREE)
      |-> out_addr_r == '0)
    else $error("nonzero address on free or out-of-memory result");

  a_oom_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != pfsa_pkg::STAT_FREE
      |-> out_ok_r == (out_status_r != pfsa_pkg::STAT_OOM))
    else $error("ok flag disagrees with allocation status");
`endif

endmodule

[test/page_frame_stack_allocator_tb.sv]
// Testbench for page_frame_stack_allocator: random-gap request driver, stalling result
// sink and an in-order scoreboard fed by a behavioral model of the free stack and regions.
// Depends on pfsa_pkg, the pfsa_*_if interfaces and the allocator RTL.
`timescale 1ns / 1ps

module page_frame_stack_allocator_tb;

  localparam int STACK_DEPTH = 1024;
  localparam int PAGE_SIZE   = 4096;
  localparam int NUM_REGIONS = 4;

  localparam int CFG_IDX_W   = pfsa_pkg::CFG_IDX_W;
  localparam int FRAME_W     = pfsa_pkg::FRAME_W;
  localparam int PAGE_ADDR_W = pfsa_pkg::PAGE_ADDR_W;

  localparam logic [CFG_IDX_W-1:0] REG_R0_FIRST = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_R0_END   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_R1_FIRST = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_R1_END   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_R2_FIRST = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_R2_END   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_R3_FIRST = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_R3_END   = 4'd7;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 4'd15;

  localparam logic [FRAME_W-1:0]     FRAME_MAX = {FRAME_W{1'b1}};
  localparam logic [PAGE_ADDR_W-1:0] PAGE_MAX  = {PAGE_ADDR_W{1'b1}};
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int RANDOM_PHASES = 4;
  localparam int PHASE_ITEMS   = 50;
  localparam int LONG_HOLD_AT  = 80;

  typedef struct packed {
    pfsa_pkg::func_t        func;
    logic [PAGE_ADDR_W-1:0] page;
  } page_request_t;

  typedef struct packed {
    logic [PAGE_ADDR_W-1:0] page_address;
    pfsa_pkg::status_t      status;
    logic                   ok;
  } alloc_result_t;

  logic clk;
  logic rst_n;

  pfsa_in_if  in_if();
  pfsa_out_if out_if();
  pfsa_cfg_if cfg_if();

  page_frame_stack_allocator #(
    .STACK_DEPTH(STACK_DEPTH),
    .PAGE_SIZE  (PAGE_SIZE),
    .NUM_REGIONS(NUM_REGIONS)
  ) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .out_if(out_if),
    .cfg_if(cfg_if)
  );

  // allocator model state
  logic [PAGE_ADDR_W-1:0] stacked_pages [STACK_DEPTH];
  int                     stacked_count;
  logic [FRAME_W-1:0]     frames_used [NUM_REGIONS];
  logic [FRAME_W-1:0]     region_first_frame [NUM_REGIONS];
  logic [FRAME_W-1:0]     region_end_frame [NUM_REGIONS];

  page_request_t pending_requests[$];
  alloc_result_t expected_results[$];

  int requests_queued;
  int results_checked;
  int mismatches;
  int reg_writes;
  int n_from_stack, n_from_region, n_oom, n_freed, n_refused;

  logic [31:0]   cycle_count;
  int            burst_left, gap_left;
  logic          drv_next_valid;
  page_request_t drv_req;
  int            hold_left;
  logic          long_hold_done;
  alloc_result_t want;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic alloc_result_t serve_request(pfsa_pkg::func_t kind,
                                                  logic [PAGE_ADDR_W-1:0] page);
    alloc_result_t r;
    logic [FRAME_W:0] frame;
    logic [63:0]      prod;
    logic             found;
    r.page_address = '0;
    r.ok = 1'b0;
    found = 1'b0;
    if (kind == pfsa_pkg::FUNC_FREE) begin
      r.status = pfsa_pkg::STAT_FREE;
      if (stacked_count < STACK_DEPTH) begin
        stacked_pages[stacked_count] = page;
        stacked_count++;
        r.ok = 1'b1;
      end
    end else if (stacked_count > 0) begin
      stacked_count--;
      r.page_address = stacked_pages[stacked_count];
      r.status = pfsa_pkg::STAT_STACK;
      r.ok = 1'b1;
    end else begin
      r.status = pfsa_pkg::STAT_OOM;
      for (int i = 0; i < NUM_REGIONS; i++) begin
        frame = {1'b0, region_first_frame[i]} + {1'b0, frames_used[i]};
        if (!found && frame < {1'b0, region_end_frame[i]}) begin
          prod = 64'(frame) * 64'(PAGE_SIZE);
          r.page_address = prod[PAGE_ADDR_W-1:0];
          frames_used[i] = frames_used[i] + 1'b1;
          r.status = pfsa_pkg::STAT_REGION;
          r.ok = 1'b1;
          found = 1'b1;
        end
      end
    end
    return r;
  endfunction

  function automatic logic [CFG_IDX_W-1:0] first_reg(int r);
    case (r)
      0: return REG_R0_FIRST;
      1: return REG_R1_FIRST;
      2: return REG_R2_FIRST;
      default: return REG_R3_FIRST;
    endcase
  endfunction

  function automatic logic [CFG_IDX_W-1:0] end_reg(int r);
    case (r)
      0: return REG_R0_END;
      1: return REG_R1_END;
      2: return REG_R2_END;
      default: return REG_R3_END;
    endcase
  endfunction

  function automatic logic [PAGE_ADDR_W-1:0] random_page();
    logic [63:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: return '0;
      1: return PAGE_MAX;
      default: return w[PAGE_ADDR_W-1:0];
    endcase
  endfunction

  task automatic queue_request(pfsa_pkg::func_t kind, logic [PAGE_ADDR_W-1:0] page);
    page_request_t q;
    q.func = kind;
    q.page = page;
    pending_requests.push_back(q);
    requests_queued++;
  endtask

  task automatic wait_drained;
    while (results_checked < requests_queued) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // leaves valid high; finish a sequence with end_reg_writes
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [FRAME_W-1:0] val);
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    cfg_if.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
  endtask

  task automatic end_reg_writes;
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic randomize_regions;
    logic [63:0]      w;
    logic [FRAME_W:0] span;
    logic [FRAME_W-1:0] first, last;
    int size;
    for (int r = 0; r < NUM_REGIONS; r++) begin
      w = {$urandom, $urandom};
      size = $urandom_range(1, 12);
      first = w[FRAME_W-1:0];
      case ($urandom_range(0, 5))
        0: last = first;
        1: begin
          if (first == '0) first = FRAME_W'(1);
          last = first - FRAME_W'($urandom_range(1, 20));
          if (last > first) last = '0;
        end
        2: begin
          last = FRAME_MAX;
          first = FRAME_MAX - frames_used[r] - FRAME_W'(size);
        end
        3: begin
          first = '0;
          last = frames_used[r] + FRAME_W'(size);
        end
        default: begin
          span = {1'b0, first} + {1'b0, frames_used[r]} + (FRAME_W+1)'(size);
          last = span[FRAME_W] ? FRAME_MAX : span[FRAME_W-1:0];
        end
      endcase
      write_reg(first_reg(r), first);
      write_reg(end_reg(r), last);
    end
    end_reg_writes();
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      cycle_count <= '0;
    end else begin
      cycle_count <= cycle_count + 1'b1;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("page_frame_stack_allocator_tb failed");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid      <= 1'b0;
      in_if.func       <= pfsa_pkg::FUNC_ALLOC;
      in_if.freed_page <= '0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      drv_next_valid = in_if.valid && !in_if.ready;
      if (!drv_next_valid) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_requests.size() != 0) begin
          drv_req = pending_requests.pop_front();
          in_if.func       <= drv_req.func;
          in_if.freed_page <= drv_req.page;
          drv_next_valid = 1'b1;
          burst_left--;
        end
      end
      in_if.valid <= drv_next_valid;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      hold_left = 0;
      long_hold_done = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else if (!long_hold_done && results_checked >= LONG_HOLD_AT) begin
      long_hold_done = 1'b1;
      hold_left = 400;
      out_if.ready <= 1'b0;
    end else begin
      case (cycle_count[8:7])
        2'd0: out_if.ready <= 1'b1;
        2'd1: out_if.ready <= 1'($urandom_range(0, 1));
        2'd2: out_if.ready <= ($urandom_range(0, 3) == 0);
        default: out_if.ready <= cycle_count[2];
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && cfg_if.valid && cfg_if.ready) begin
      reg_writes++;
      case (cfg_if.index)
        REG_R0_FIRST: region_first_frame[0] = cfg_if.data;
        REG_R0_END:   region_end_frame[0]   = cfg_if.data;
        REG_R1_FIRST: region_first_frame[1] = cfg_if.data;
        REG_R1_END:   region_end_frame[1]   = cfg_if.data;
        REG_R2_FIRST: region_first_frame[2] = cfg_if.data;
        REG_R2_END:   region_end_frame[2]   = cfg_if.data;
        REG_R3_FIRST: region_first_frame[3] = cfg_if.data;
        REG_R3_END:   region_end_frame[3]   = cfg_if.data;
        default: ;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready)
      expected_results.push_back(serve_request(pfsa_pkg::func_t'(in_if.func),
                                               in_if.freed_page));
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      results_checked++;
      if (expected_results.size() == 0) begin
        $error("unexpected result beat: page_address %h status %0d ok %0b",
               out_if.page_address, out_if.status, out_if.ok);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (out_if.page_address !== want.page_address) begin
          $error("page_address: expected %h, got %h", want.page_address, out_if.page_address);
          mismatches++;
        end
        if (out_if.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_if.status);
          mismatches++;
        end
        if (out_if.ok !== want.ok) begin
          $error("ok: expected %0b, got %0b", want.ok, out_if.ok);
          mismatches++;
        end
        case (want.status)
          pfsa_pkg::STAT_STACK:  n_from_stack++;
          pfsa_pkg::STAT_REGION: n_from_region++;
          pfsa_pkg::STAT_OOM:    n_oom++;
          default: if (want.ok) n_freed++; else n_refused++;
        endcase
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.func = pfsa_pkg::FUNC_ALLOC;
    in_if.freed_page = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    stacked_count = 0;
    requests_queued = 0;
    results_checked = 0;
    mismatches = 0;
    reg_writes = 0;
    n_from_stack = 0;
    n_from_region = 0;
    n_oom = 0;
    n_freed = 0;
    n_refused = 0;
    for (int i = 0; i < NUM_REGIONS; i++) begin
      frames_used[i] = '0;
      region_first_frame[i] = '0;
      region_end_frame[i] = '0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    repeat (SETTLE_CYCLES) @(posedge clk);

    // regions cleared: out of memory, then stack push/pop at the page extremes
    queue_request(pfsa_pkg::FUNC_ALLOC, '0);
    queue_request(pfsa_pkg::FUNC_FREE, '0);
    queue_request(pfsa_pkg::FUNC_FREE, PAGE_MAX);
    queue_request(pfsa_pkg::FUNC_ALLOC, '0);
    queue_request(pfsa_pkg::FUNC_ALLOC, '0);
    queue_request(pfsa_pkg::FUNC_ALLOC, PAGE_MAX);
    wait_drained();

    // two-frame region, inverted region, empty region, topmost frame, unmapped index
    write_reg(REG_R0_FIRST, 36'd5);
    write_reg(REG_R0_END, 36'd7);
    write_reg(REG_R1_FIRST, 36'd20);
    write_reg(REG_R1_END, 36'd10);
    write_reg(REG_R2_FIRST, 36'd30);
    write_reg(REG_R2_END, 36'd30);
    write_reg(REG_R3_FIRST, FRAME_MAX - 1'b1);
    write_reg(REG_R3_END, FRAME_MAX);
    write_reg(REG_UNMAPPED, FRAME_MAX);
    end_reg_writes();
    repeat (4) queue_request(pfsa_pkg::FUNC_ALLOC, '0);
    queue_request(pfsa_pkg::FUNC_FREE, 48'hA5A5_5A5A_0F0F);
    queue_request(pfsa_pkg::FUNC_ALLOC, '0);
    queue_request(pfsa_pkg::FUNC_ALLOC, '0);
    wait_drained();

    // cursor kept across rewrite: region 0 spans everything, resumes at used count
    write_reg(REG_R0_FIRST, '0);
    write_reg(REG_R0_END, FRAME_MAX);
    end_reg_writes();
    queue_request(pfsa_pkg::FUNC_ALLOC, '0);
    queue_request(pfsa_pkg::FUNC_ALLOC, '0);
    wait_drained();
    write_reg(REG_R0_FIRST, 36'd4);
    write_reg(REG_R0_END, 36'd6);
    end_reg_writes();
    queue_request(pfsa_pkg::FUNC_ALLOC, '0);
    queue_request(pfsa_pkg::FUNC_ALLOC, '0);
    wait_drained();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      int alloc_pct;
      alloc_pct = 30 + 10 * (p % 4);
      randomize_regions();
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 99) < alloc_pct) queue_request(pfsa_pkg::FUNC_ALLOC, random_page());
        else queue_request(pfsa_pkg::FUNC_FREE, random_page());
      end
      wait_drained();
    end

    // fill the stack past full, then pop a few and push again
    randomize_regions();
    for (int k = 0; k < STACK_DEPTH - stacked_count + 3; k++)
      queue_request(pfsa_pkg::FUNC_FREE, random_page());
    repeat (5) queue_request(pfsa_pkg::FUNC_ALLOC, '0);
    repeat (2) queue_request(pfsa_pkg::FUNC_FREE, random_page());
    wait_drained();

    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      mismatches++;
    end
    $display("%0d requests, %0d register writes: %0d stack pops, %0d region pages, %0d oom",
             requests_queued, reg_writes, n_from_stack, n_from_region, n_oom);
    $display("frees taken %0d, frees refused on full stack %0d, mismatches %0d",
             n_freed, n_refused, mismatches);
    if (mismatches == 0) begin
      $display("page_frame_stack_allocator_tb passed");
    end else begin
      $display("page_frame_stack_allocator_tb failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/pfsa_pkg.sv
rtl/pfsa_in_if.sv
rtl/pfsa_out_if.sv
rtl/pfsa_cfg_if.sv
rtl/pfsa_stack.sv
rtl/page_frame_stack_allocator.sv
test/page_frame_stack_allocator_tb.sv
